// ===== src/deq_pkg.sv =====
// deq_pkg: types, sizes and codes for the double-ended queue
// used by deq_cell and double_ended_queue_unit
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int FIELD_COUNT_W = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // what every cell of the row does at a clock edge
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_CLEAR
    } t_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic  valid;
        t_word data;
    } t_link;

    typedef struct packed {
        logic [2:0] opcode;
        t_word      push_value;
    } t_in_item;

    typedef struct packed {
        t_word                    popped_value;
        t_word                    front_value;
        t_word                    back_value;
        logic [FIELD_COUNT_W-1:0] element_count;
        logic [1:0]               status;
    } t_out_item;

endpackage

// ===== src/deq_cell.sv =====
// deq_cell: one storage cell of the deque row, holds one word and its valid bit
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_cell
    import deq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_word i_push,
    input  t_link i_left,
    input  t_link i_right,
    output t_link o_link,
    output t_word o_back_tap
);

    logic  r_valid;
    logic  n_valid;
    t_word r_data;
    t_word n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_cmd)
            CMD_PUSH_FRONT: begin
                n_valid = i_left.valid;
                n_data  = i_left.data;
            end
            CMD_PUSH_BACK: begin
                // first empty cell takes the word
                if (!r_valid && i_left.valid) begin
                    n_valid = 1'b1;
                    n_data  = i_push;
                end
            end
            CMD_POP_FRONT: begin
                n_valid = i_right.valid;
                n_data  = i_right.data;
            end
            CMD_POP_BACK: begin
                n_valid = r_valid && i_right.valid;
            end
            CMD_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;
    // last occupied cell drives the back word, all others give zero
    assign o_back_tap   = (r_valid && !i_right.valid) ? r_data : '0;

endmodule

// ===== src/double_ended_queue_unit.sv =====
// double_ended_queue_unit: deque built as a row of shifting cells, front at cell 0
// depends on deq_pkg and deq_cell
//
//  port       dir  handshake           word
//  i_item     in   i_start & !o_busy   t_in_item (opcode, push_value)
//  o_result   out  o_strobe            t_out_item (popped, ends, count, status)
//
//  one word per cycle: the cell row updates at the accepting edge and the result
//  is shown for the single following cycle, so o_busy stays low
//  push front and pop front shift the whole row by one cell in that cycle
//  synchronous active-low reset empties the row, no clearing pass is needed
//  results cannot be stalled, each strobe lasts exactly one cycle
`timescale 1ns / 1ps

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_link            links [DEPTH];
    t_word            taps  [DEPTH];
    t_cmd             cmd;
    logic             accept;
    logic             is_empty;
    logic             is_full;
    t_word            back_word;
    t_word            pop_word;
    logic [1:0]       status;

    logic             r_strobe;
    t_word            r_popped;
    logic [1:0]       r_status;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign accept   = i_start && !o_busy;
    assign is_empty = !links[0].valid;
    assign is_full  = links[DEPTH-1].valid;

    always_comb begin
        back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_word = back_word | taps[k];
        end
    end

    always_comb begin
        cmd      = CMD_HOLD;
        status   = ST_OK;
        pop_word = '0;
        n_count  = r_count;
        case (i_item.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    cmd     = (i_item.opcode == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                : CMD_PUSH_BACK;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd      = CMD_POP_FRONT;
                    pop_word = links[0].data;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd      = CMD_POP_BACK;
                    pop_word = back_word;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                cmd     = CMD_CLEAR;
                n_count = '0;
            end
            OP_READ: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end
            end
            default: begin
                cmd = CMD_HOLD;
            end
        endcase
        if (!accept) begin
            cmd     = CMD_HOLD;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_link left_in;
        t_link right_in;

        if (g == 0) begin : g_head
            assign left_in.valid = 1'b1;
            assign left_in.data  = i_item.push_value;
        end else begin : g_mid
            assign left_in = links[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_in.valid = 1'b0;
            assign right_in.data  = '0;
        end else begin : g_body
            assign right_in = links[g+1];
        end

        deq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_push     (i_item.push_value),
            .i_left     (left_in),
            .i_right    (right_in),
            .o_link     (links[g]),
            .o_back_tap (taps[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= accept;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped <= pop_word;
            r_status <= status;
        end
    end

    assign o_busy   = 1'b0;
    assign o_strobe = r_strobe;

    // ends are read from the row after the update
    assign o_result.popped_value  = r_popped;
    assign o_result.front_value   = links[0].valid ? links[0].data : '0;
    assign o_result.back_value    = back_word;
    assign o_result.element_count = FIELD_COUNT_W'(r_count);
    assign o_result.status        = r_status;

endmodule
